### hw/rtl/vvi_pkg.sv
// vvi_pkg: types and constants of the vortex velocity induction block
// no dependencies; used by vvi_div, vortex_velocity_induction and the testbench
package vvi_pkg;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_FREE_X = 2'd0;
  localparam logic [1:0] REG_FREE_Y = 2'd1;
  localparam logic [1:0] REG_CORE   = 2'd2;

  // round(2^32 / (2*pi))
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  // quotient width: |gamma| (31 bit + sign) times |d| (32 bit)
  localparam int NUM_W = 63;
  // quotient bits kept before the term is clamped
  localparam int Q_KEEP = 34;
  // accumulator width, wide enough that no sum of terms overflows
  localparam int ACC_W = 64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FETCH,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_DEN,
    S_NUM,
    S_DSTART,
    S_DIV,
    S_SCL,
    S_ACC,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] strength;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               dropped;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/vvi_div.sv
// vvi_div: restoring divider, one quotient bit per cycle
// depends on vvi_pkg for the numerator width and the status struct
module vvi_div #(
  parameter int DEN_W = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [vvi_pkg::NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]           den,
  output logic [vvi_pkg::NUM_W-1:0]  quo,
  output vvi_pkg::div_stat_t         stat
);

  localparam int NW  = vvi_pkg::NUM_W;
  localparam int CNW = $clog2(NW);

  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NW-1:0]    quo_r;
  logic [CNW-1:0]   cnt_r;
  logic             run_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one trial subtraction a cycle
  always_comb begin
    trial = {rem_r, quo_r[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + CNW'(1);
      if (cnt_r == CNW'(NW - 1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // quotient shifts in where the numerator shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

  assign quo       = quo_r;
  assign stat.busy = run_r;
  assign stat.done = run_r && (cnt_r == CNW'(NW - 1));

endmodule

### hw/rtl/vortex_velocity_induction.sv
// vortex_velocity_induction: point vortex store and Biot-Savart velocity query
// depends on vvi_pkg and vvi_div
//
// Commands are taken when start is high and busy is low. Clear and add do
// not raise busy and give no result. A query walks the stored vortices one
// at a time through one shared 32x32 multiplier and one bit-serial divider:
// each vortex is fetched, its offsets and the denominator from its squared
// radius are formed, then each velocity component in turn takes a numerator
// product, a division, a scaling by 1/(2*pi) and an accumulation. The result
// strobes on out_valid in the first cycle with busy low again; it is held for
// that one cycle only and cannot be stalled. Configuration writes are always
// ready and belong to idle periods; the block itself does not enforce this. Adds
// beyond MAX_VORTICES are dropped and set the sticky dropped flag until the next clear.
module vortex_velocity_induction #(
  parameter int MAX_VORTICES = 256,
  parameter int FRAC_BITS    = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  vvi_pkg::in_item_t     in_item,
  output logic                  out_valid,
  output vvi_pkg::out_item_t    out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int AW    = $clog2(MAX_VORTICES);
  localparam int CW    = $clog2(MAX_VORTICES + 1);
  localparam int DEN_W = 64 - FRAC_BITS;
  localparam int NW    = vvi_pkg::NUM_W;
  localparam int AccW  = vvi_pkg::ACC_W;
  localparam logic [31:0] FREE_X_RST = 32'(64'd1 << FRAC_BITS);
  localparam logic [30:0] CORE_RST   = 31'((64'd1 << FRAC_BITS) / 1000);

  vvi_pkg::state_t state_r, state_nxt;

  // configuration and store control
  logic signed [31:0] free_x_r, free_y_r;
  logic [30:0]        core_r;
  logic [CW-1:0]      cnt_r;
  logic               drop_r;
  logic [AW-1:0]      k_r;
  logic               axis_r;

  // vortex store and its registered read port
  logic [95:0] vtx_mem [MAX_VORTICES];
  logic [95:0] rd_data_r;

  // per-vortex datapath
  logic signed [31:0] qx_r, qy_r;
  logic [31:0]        ux_r, uy_r, ag_r;
  logic               sg_r, sdx_r, ydpos_r;
  logic [63:0]        sx_r, prod_r;
  logic [DEN_W-1:0]   den_r;
  logic [NW-1:0]      num_r;
  logic signed [AccW-1:0] accx_r, accy_r;
  logic               out_valid_r;
  vvi_pkg::out_item_t out_r;

  logic accept;
  logic cfg_wr;
  logic div_start;
  logic [NW-1:0] div_q;
  vvi_pkg::div_stat_t div_stat;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign busy      = state_r != vvi_pkg::S_IDLE;
  assign div_start = state_r == vvi_pkg::S_DSTART;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    unique case (state_r)
      vvi_pkg::S_SQX: begin
        mul_a = ux_r;
        mul_b = ux_r;
      end
      vvi_pkg::S_SQY: begin
        mul_a = uy_r;
        mul_b = uy_r;
      end
      vvi_pkg::S_NUM: begin
        mul_a = ag_r;
        mul_b = axis_r ? ux_r : uy_r;
      end
      vvi_pkg::S_SCL: begin
        mul_a = div_q[31:0];
        mul_b = {2'b00, vvi_pkg::INV_TWO_PI_Q32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // offsets of the query point from the fetched vortex
  logic signed [32:0] dx, dy;
  logic signed [31:0] vx, vy, vg;
  always_comb begin
    vx = rd_data_r[95:64];
    vy = rd_data_r[63:32];
    vg = rd_data_r[31:0];
    dx = 33'(qx_r) - 33'(vx);
    dy = 33'(qy_r) - 33'(vy);
  end

  // denominator: max(r^2 >> FRAC_BITS, core), a zero core taken as 1, r^2 saturating
  logic [64:0]      r2;
  logic [63:0]      r2s;
  logic [DEN_W-1:0] den_s, core_w;
  always_comb begin
    r2     = {1'b0, sx_r} + {1'b0, prod_r};
    r2s    = r2[64] ? '1 : r2[63:0];
    den_s  = r2s[63:FRAC_BITS];
    core_w = (core_r == '0) ? DEN_W'(1) : DEN_W'(core_r);
  end

  // scaled term magnitude and sign
  logic [40:0]            mag;
  logic                   neg;
  logic signed [AccW-1:0] term;
  always_comb begin
    if (|div_q[NW-1:vvi_pkg::Q_KEEP]) begin
      mag = 41'd1 << 40;
    end else begin
      mag = 41'(prod_r[63:32]) + 41'(div_q[33:32]) * 41'(vvi_pkg::INV_TWO_PI_Q32);
    end
    neg  = axis_r ? (sg_r ^ sdx_r) : (sg_r ^ ydpos_r);
    term = neg ? -AccW'(mag) : AccW'(mag);
  end

  logic last_vtx;
  assign last_vtx = (CW'(k_r) + CW'(1)) == cnt_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vvi_pkg::S_IDLE: begin
        if (accept && in_item.cmd == vvi_pkg::CMD_QUERY) begin
          state_nxt = (cnt_r == '0) ? vvi_pkg::S_OUT : vvi_pkg::S_FETCH;
        end
      end
      vvi_pkg::S_FETCH:  state_nxt = vvi_pkg::S_DIFF;
      vvi_pkg::S_DIFF:   state_nxt = vvi_pkg::S_SQX;
      vvi_pkg::S_SQX:    state_nxt = vvi_pkg::S_SQY;
      vvi_pkg::S_SQY:    state_nxt = vvi_pkg::S_DEN;
      vvi_pkg::S_DEN:    state_nxt = vvi_pkg::S_NUM;
      vvi_pkg::S_NUM:    state_nxt = vvi_pkg::S_DSTART;
      vvi_pkg::S_DSTART: state_nxt = vvi_pkg::S_DIV;
      vvi_pkg::S_DIV: begin
        if (div_stat.done) begin
          state_nxt = vvi_pkg::S_SCL;
        end
      end
      vvi_pkg::S_SCL:    state_nxt = vvi_pkg::S_ACC;
      vvi_pkg::S_ACC: begin
        if (!axis_r) begin
          state_nxt = vvi_pkg::S_NUM;
        end else if (last_vtx) begin
          state_nxt = vvi_pkg::S_OUT;
        end else begin
          state_nxt = vvi_pkg::S_FETCH;
        end
      end
      vvi_pkg::S_OUT:    state_nxt = vvi_pkg::S_IDLE;
      default:           state_nxt = vvi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vvi_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_x_r <= FREE_X_RST;
      free_y_r <= '0;
      core_r   <= CORE_RST;
    end else if (cfg_wr) begin
      priority case (cfg_index)
        vvi_pkg::REG_FREE_X: free_x_r <= cfg_data;
        vvi_pkg::REG_FREE_Y: free_y_r <= cfg_data;
        vvi_pkg::REG_CORE:   core_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // store fill count and sticky drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (accept) begin
      if (in_item.cmd == vvi_pkg::CMD_CLEAR) begin
        cnt_r  <= '0;
        drop_r <= 1'b0;
      end else if (in_item.cmd == vvi_pkg::CMD_ADD) begin
        if (cnt_r == CW'(MAX_VORTICES)) begin
          drop_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
    end
  end

  // vortex memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (accept && in_item.cmd == vvi_pkg::CMD_ADD && cnt_r != CW'(MAX_VORTICES)) begin
      vtx_mem[cnt_r[AW-1:0]] <= {in_item.pos_x, in_item.pos_y, in_item.strength};
    end
    rd_data_r <= vtx_mem[k_r];
  end

  // walk index and component select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      axis_r <= 1'b0;
    end else if (state_r == vvi_pkg::S_IDLE) begin
      k_r    <= '0;
      axis_r <= 1'b0;
    end else if (state_r == vvi_pkg::S_ACC) begin
      axis_r <= !axis_r;
      if (axis_r && !last_vtx) begin
        k_r <= k_r + AW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      vvi_pkg::S_IDLE: begin
        qx_r   <= in_item.pos_x;
        qy_r   <= in_item.pos_y;
        accx_r <= AccW'(free_x_r);
        accy_r <= AccW'(free_y_r);
      end
      vvi_pkg::S_DIFF: begin
        ux_r    <= dx[32] ? 32'(-dx) : dx[31:0];
        uy_r    <= dy[32] ? 32'(-dy) : dy[31:0];
        ag_r    <= vg[31] ? 32'(-33'(vg)) : 32'(vg);
        sg_r    <= vg[31];
        sdx_r   <= dx[32];
        ydpos_r <= !dy[32] && (dy != '0);
      end
      vvi_pkg::S_SQX: sx_r <= mul_p;
      vvi_pkg::S_SQY: prod_r <= mul_p;
      vvi_pkg::S_DEN: den_r <= (den_s < core_w) ? core_w : den_s;
      vvi_pkg::S_NUM: num_r <= mul_p[NW-1:0];
      vvi_pkg::S_SCL: prod_r <= mul_p;
      vvi_pkg::S_ACC: begin
        if (axis_r) begin
          accy_r <= accy_r + term;
        end else begin
          accx_r <= accx_r + term;
        end
      end
      default: ;
    endcase
  end

  // saturated result, strobed for one cycle
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [31:0] r;
    if (v > AccW'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (v < -AccW'(33'sh080000000)) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= state_r == vvi_pkg::S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == vvi_pkg::S_OUT) begin
      out_r.vel_x   <= sat32(accx_r);
      out_r.vel_y   <= sat32(accy_r);
      out_r.dropped <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  vvi_div #(
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .quo   (div_q),
    .stat  (div_stat)
  );

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a query always makes the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.cmd == vvi_pkg::CMD_QUERY) |=> busy)
    else $error("query accepted without going busy");

  // fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_VORTICES))
    else $error("vortex count beyond store depth");

  // divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == vvi_pkg::S_DIV)
    else $error("divider running outside its wait state");

endmodule

### verif/testbench.sv
// testbench: self-checking bench for vortex_velocity_induction
// depends on vvi_pkg and the rtl of vortex_velocity_induction
// directed table, zero-core and full-store tests, then random command sequences, checked against a local predictor
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH     = 256;
  localparam int FRAC      = 24;
  localparam int QUIET_MAX = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  vvi_pkg::in_item_t  in_item;
  logic               out_valid;
  vvi_pkg::out_item_t out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;

  vortex_velocity_induction dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  // predictor state
  longint    stream_x, stream_y;
  bit [30:0] core_sq;
  longint    vort_x[DEPTH], vort_y[DEPTH], vort_g[DEPTH];
  int        vort_n;
  bit        drop_seen;

  vvi_pkg::out_item_t vel_queue[$];
  int        errors, quiet, n_queries, n_adds, n_drops;

  typedef struct {
    vvi_pkg::in_item_t  it;
    bit                 fixed_chk;
    vvi_pkg::out_item_t fixed;
  } row_t;

  function automatic bit [63:0] umag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // one component of one vortex: gamma * d / (2 pi den), clamped when huge
  function automatic longint induced_term(longint g, longint d, bit [63:0] den);
    bit        neg;
    bit [63:0] num, quo;
    longint    m;
    neg = (g < 0) != (d < 0);
    num = umag(g) * umag(d);
    quo = num / den;
    if (quo >= (64'd1 << 34)) m = longint'(1) << 40;
    else m = longint'((quo * 64'd683565276) >> 32);
    return neg ? -m : m;
  endfunction

  function automatic logic signed [31:0] sat_word(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic vvi_pkg::out_item_t velocity_at(longint qx, longint qy);
    vvi_pkg::out_item_t r;
    longint    ax, ay, dx, dy;
    bit [63:0] ux, uy, den, core;
    bit [64:0] r2;
    core = (core_sq == 0) ? 64'd1 : 64'(core_sq);
    ax = stream_x;
    ay = stream_y;
    for (int k = 0; k < vort_n; k++) begin
      dx = qx - vort_x[k];
      dy = qy - vort_y[k];
      ux = umag(dx);
      uy = umag(dy);
      r2 = {1'b0, ux * ux} + {1'b0, uy * uy};
      den = r2[64] ? (64'hffff_ffff_ffff_ffff >> FRAC) : (r2[63:0] >> FRAC);
      if (den < core) den = core;
      ax += induced_term(vort_g[k], -dy, den);
      ay += induced_term(vort_g[k], dx, den);
    end
    r.vel_x = sat_word(ax);
    r.vel_y = sat_word(ay);
    r.dropped = drop_seen;
    return r;
  endfunction

  // apply one accepted command; returns 1 with the velocity for a query
  function automatic bit apply_command(vvi_pkg::in_item_t it,
                                       output vvi_pkg::out_item_t vel);
    vel = '0;
    case (it.cmd)
      vvi_pkg::CMD_CLEAR: begin
        vort_n = 0;
        drop_seen = 1'b0;
      end
      vvi_pkg::CMD_ADD: begin
        n_adds++;
        if (vort_n >= DEPTH) begin
          drop_seen = 1'b1;
          n_drops++;
        end else begin
          vort_x[vort_n] = longint'($signed(it.pos_x));
          vort_y[vort_n] = longint'($signed(it.pos_y));
          vort_g[vort_n] = longint'($signed(it.strength));
          vort_n++;
        end
      end
      vvi_pkg::CMD_QUERY: begin
        vel = velocity_at(longint'($signed(it.pos_x)), longint'($signed(it.pos_y)));
        n_queries++;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // command transfer; use_fixed replaces the predicted velocity
  task automatic send_cmd(vvi_pkg::in_item_t it, bit use_fixed = 0,
                          vvi_pkg::out_item_t fixed = '0);
    vvi_pkg::out_item_t vel;
    vvi_pkg::out_item_t exp_v;
    in_item = it;
    start = 1'b1;
    do @(posedge clk); while (busy);
    if (apply_command(it, vel)) begin
      exp_v = use_fixed ? fixed : vel;
      vel_queue = {vel_queue, exp_v};
    end
    @(negedge clk);
  endtask

  task automatic idle_for(int n);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // mostly short gaps, a few long ones, often none
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vvi_pkg::REG_FREE_X: stream_x = longint'($signed(val));
      vvi_pkg::REG_FREE_Y: stream_y = longint'($signed(val));
      vvi_pkg::REG_CORE:   core_sq = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // wait for all velocities, then let a trailing add or clear finish
  task automatic drain();
    start = 1'b0;
    while (vel_queue.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic vvi_pkg::in_item_t mk(logic [1:0] c, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] g);
    vvi_pkg::in_item_t it;
    it.cmd = c;
    it.pos_x = x;
    it.pos_y = y;
    it.strength = g;
    return it;
  endfunction

  function automatic row_t mk_row(vvi_pkg::in_item_t it, bit chk = 0,
                                  vvi_pkg::out_item_t fx = '0);
    row_t r;
    r.it = it;
    r.fixed_chk = chk;
    r.fixed = fx;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
  endfunction

  // result checker and quiet-cycle count
  always @(posedge clk) begin
    vvi_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (out_valid) begin
        if (vel_queue.size() == 0) begin
          $error("velocity transfer with nothing expected");
          errors++;
        end else begin
          want = vel_queue.pop_front();
          if (out_item.vel_x !== want.vel_x) begin
            $error("vel_x expected %0d actual %0d", want.vel_x, out_item.vel_x);
            errors++;
          end
          if (out_item.vel_y !== want.vel_y) begin
            $error("vel_y expected %0d actual %0d", want.vel_y, out_item.vel_y);
            errors++;
          end
          if (out_item.dropped !== want.dropped) begin
            $error("dropped expected %0b actual %0b", want.dropped, out_item.dropped);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (quiet >= QUIET_MAX) begin
      $display("watchdog: %0d cycles without a transfer", quiet);
      $display("[vortex_velocity_induction] ERROR");
      $finish;
    end
  end

  initial begin
    row_t               rows[$];
    vvi_pkg::out_item_t fs_only;
    int                 seq_len;
    logic [31:0]        cfg_x[6], cfg_y[6], cfg_c[6];

    errors = 0; quiet = 0; n_queries = 0; n_adds = 0; n_drops = 0;
    start = 1'b0; in_item = '0; cfg_valid = 1'b0; cfg_index = vvi_pkg::REG_FREE_X;
    cfg_data = '0;
    stream_x = longint'(1) << FRAC; stream_y = 0; core_sq = 31'((1 << FRAC) / 1000);
    vort_n = 0; drop_seen = 1'b0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed table: empty store gives the free stream after reset
    fs_only.vel_x = 32'sh0100_0000; fs_only.vel_y = '0; fs_only.dropped = 1'b0;
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0), 1, fs_only)};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff,
                            32'hffff_ffff))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_ADD, 32'h0, 32'h0, 32'h7fff_ffff))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h0100_0000, 32'h0, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h0000_0001, 32'h0, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_ADD, 32'h0200_0000, 32'hfe00_0000, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h0080_0000, 32'h0080_0000, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h1234_5678, 32'h8765_4321, 32'h0),
                         1, fs_only)};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_ADD, 32'h7fff_ffff, 32'h8000_0000,
                            32'hffff_ffff))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h8000_0000, 32'h7fff_ffff, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_QUERY, 32'h7fff_ffff, 32'h8000_0001, 32'h0))};
    rows = {rows, mk_row(mk(vvi_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0))};
    foreach (rows[i]) begin
      send_cmd(rows[i].it, rows[i].fixed_chk, rows[i].fixed);
      idle_for(gap_len());
    end
    drain();

    // zero core acts as the smallest step
    write_reg(vvi_pkg::REG_CORE, 32'h0);
    send_cmd(mk(vvi_pkg::CMD_ADD, 32'h0, 32'h0, 32'h0100_0000));
    send_cmd(mk(vvi_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0));
    send_cmd(mk(vvi_pkg::CMD_QUERY, 32'h0, 32'h0000_0001, 32'h0));
    send_cmd(mk(vvi_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0));
    drain();

    // fill the store, overflow it, then one full-length query
    for (int i = 0; i < DEPTH + 3; i++) begin
      send_cmd(mk(vvi_pkg::CMD_ADD, rand_coord(), rand_coord(), $urandom));
      if ($urandom_range(7) == 0) idle_for(gap_len());
    end
    send_cmd(mk(vvi_pkg::CMD_QUERY, rand_coord(), rand_coord(), $urandom));
    send_cmd(mk(vvi_pkg::CMD_CLEAR, 32'h0, 32'h0, 32'h0));
    send_cmd(mk(vvi_pkg::CMD_QUERY, 32'h0, 32'h0, 32'h0));
    drain();

    // register settings per phase, extremes first
    cfg_x = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hff00_0000, $urandom, $urandom};
    cfg_y = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0080_0000, $urandom, $urandom};
    cfg_c = '{32'h7fff_ffff, 32'h0000_0001, 32'h0000_4189, 32'h8000_0000,
              32'h0100_0000, $urandom};

    // random command sequences: mostly clear, a few adds, several queries, else single commands
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(vvi_pkg::REG_FREE_X, cfg_x[ph]);
      write_reg(vvi_pkg::REG_FREE_Y, cfg_y[ph]);
      write_reg(vvi_pkg::REG_CORE, cfg_c[ph]);
      for (int n = 0; n < 120; n += seq_len) begin
        int r;
        r = $urandom_range(99);
        seq_len = 1;
        if (r < 80) begin
          int n_add, n_qry;
          n_add = $urandom_range(0, 6);
          n_qry = $urandom_range(1, 4);
          seq_len = 1 + n_add + n_qry;
          send_cmd(mk(vvi_pkg::CMD_CLEAR, $urandom, $urandom, $urandom));
          idle_for(gap_len());
          repeat (n_add) begin
            send_cmd(mk(vvi_pkg::CMD_ADD, rand_coord(), rand_coord(), $urandom));
            idle_for(gap_len());
          end
          repeat (n_qry) begin
            send_cmd(mk(vvi_pkg::CMD_QUERY, rand_coord(), rand_coord(), $urandom));
            idle_for(gap_len());
          end
        end else if (r < 90) begin
          if (vort_n < 12) begin
            send_cmd(mk(vvi_pkg::CMD_ADD, rand_coord(), rand_coord(), $urandom));
          end else begin
            send_cmd(mk(vvi_pkg::CMD_QUERY, rand_coord(), rand_coord(), $urandom));
          end
        end else if (r < 95) begin
          send_cmd(mk(vvi_pkg::CMD_UNUSED, $urandom, $urandom, $urandom));
        end else if (vort_n < 12) begin
          send_cmd(mk(vvi_pkg::CMD_QUERY, $urandom, $urandom, $urandom));
        end else begin
          send_cmd(mk(vvi_pkg::CMD_CLEAR, $urandom, $urandom, $urandom));
        end
        // hold off now and then until every velocity is back
        if ($urandom_range(15) == 0) drain();
      end
      drain();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("covered %0d queries and %0d adds (%0d dropped on a full store)",
             n_queries, n_adds, n_drops);
    $display("across six register settings plus directed extremes; %0d mismatches", errors);
    if (errors == 0 && vel_queue.size() == 0) begin
      $display("[vortex_velocity_induction] OK");
    end else begin
      $display("[vortex_velocity_induction] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/vvi_pkg.sv
hw/rtl/vvi_div.sv
hw/rtl/vortex_velocity_induction.sv
verif/testbench.sv
